[hw/rtl/lobm_pkg.sv]
// ----------------------------------------------------------------------------
// lobm_pkg: shared types and codes of the order book matcher
// Command codes, result kinds, datapath operations and the control and
// status groups between the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package lobm_pkg;

  localparam int PRICE_W = 31;
  localparam int QTY_W   = 31;
  localparam int ID_W    = 32;
  localparam int SUM_W   = 36;

  typedef enum logic [1:0] {
    FUNC_NEW    = 2'd0,
    FUNC_MODIFY = 2'd1,
    FUNC_CANCEL = 2'd2,
    FUNC_PRINT  = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    KIND_TRADE    = 3'd0,
    KIND_SELL_HDR = 3'd1,
    KIND_BUY_HDR  = 3'd2,
    KIND_LEVEL    = 3'd3,
    KIND_REJECT   = 3'd4
  } kind_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LATCH,
    OP_FIND,
    OP_CANCEL,
    OP_MODW,
    OP_CROSS,
    OP_FILL,
    OP_REST,
    OP_HDR,
    OP_LIST,
    OP_LEVEL,
    OP_FLUSH
  } op_t;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    func_t func;
    logic  args_ok;
    logic  id_found;
    logic  scan_last;
    logic  best_found;
    logic  rem_zero;
    logic  can_emit;
    logic  flush_ok;
    logic  top_found;
    logic  list_buy;
  } status_t;

  typedef struct packed {
    kind_t              kind;
    logic [ID_W-1:0]    first_id;
    logic [PRICE_W-1:0] first_price;
    logic [ID_W-1:0]    second_id;
    logic [PRICE_W-1:0] second_price;
    logic [SUM_W-1:0]   qty;
  } result_t;

endpackage

`default_nettype wire

[hw/rtl/lobm_ctrl.sv]
// ----------------------------------------------------------------------------
// lobm_ctrl: command sequencer
// Steps each command through id lookup, matching scans, fills, resting and
// book listing, issuing at most one datapath operation per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module lobm_ctrl (
  input  wire              clk,
  input  wire              rst,
  input  wire              in_valid,
  output logic             in_stall,
  input  lobm_pkg::status_t status,
  output lobm_pkg::cmd_t   cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_FIND, S_DISP, S_MODW, S_CROSS, S_FILL,
    S_REST, S_HDR, S_LIST, S_LEVEL, S_DONE
  } state_t;

  state_t state;
  state_t state_next;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cmd.op     = lobm_pkg::OP_NONE;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op     = lobm_pkg::OP_LATCH;
          state_next = S_FIND;
        end
      end
      S_FIND: begin
        cmd.op = lobm_pkg::OP_FIND;
        if (status.scan_last) state_next = S_DISP;
      end
      S_DISP: begin
        case (status.func)
          lobm_pkg::FUNC_NEW:
            state_next = (status.args_ok && !status.id_found) ? S_CROSS : S_DONE;
          lobm_pkg::FUNC_MODIFY:
            state_next = (status.args_ok && status.id_found) ? S_MODW : S_DONE;
          lobm_pkg::FUNC_CANCEL: begin
            cmd.op     = lobm_pkg::OP_CANCEL;
            state_next = S_DONE;
          end
          default: state_next = S_HDR;
        endcase
      end
      S_MODW: begin
        cmd.op     = lobm_pkg::OP_MODW;
        state_next = S_CROSS;
      end
      S_CROSS: begin
        if (status.rem_zero) begin
          state_next = S_REST;
        end else begin
          cmd.op = lobm_pkg::OP_CROSS;
          if (status.scan_last) state_next = S_FILL;
        end
      end
      S_FILL: begin
        if (!status.best_found) begin
          state_next = S_REST;
        end else if (status.can_emit) begin
          cmd.op     = lobm_pkg::OP_FILL;
          state_next = S_CROSS;
        end
      end
      S_REST: begin
        if (status.can_emit) begin
          cmd.op     = lobm_pkg::OP_REST;
          state_next = S_DONE;
        end
      end
      S_HDR: begin
        if (status.can_emit) begin
          cmd.op     = lobm_pkg::OP_HDR;
          state_next = S_LIST;
        end
      end
      S_LIST: begin
        cmd.op = lobm_pkg::OP_LIST;
        if (status.scan_last) state_next = S_LEVEL;
      end
      S_LEVEL: begin
        if (status.can_emit) begin
          cmd.op = lobm_pkg::OP_LEVEL;
          if (status.top_found || !status.list_buy) state_next = S_LIST;
          else state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (status.flush_ok) begin
          cmd.op     = lobm_pkg::OP_FLUSH;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/lobm_dp.sv]
// ----------------------------------------------------------------------------
// lobm_dp: book storage and scan datapath
// Holds the resting orders, scans them one slot per cycle for id lookup,
// best opposite order and price levels, and buffers results for output.
// ----------------------------------------------------------------------------
`default_nettype none

module lobm_dp #(
  parameter int BOOK_DEPTH = 32,
  parameter int SEQ_WIDTH  = 32
) (
  input  wire                              clk,
  input  wire                              rst,
  input  lobm_pkg::cmd_t                   cmd,
  output lobm_pkg::status_t                status,
  input  wire [1:0]                        func,
  input  wire                              is_buy,
  input  wire                              is_gfd,
  input  wire [lobm_pkg::PRICE_W-1:0]      price,
  input  wire [lobm_pkg::QTY_W-1:0]        quantity,
  input  wire [lobm_pkg::ID_W-1:0]         order_id,
  output logic                             out_valid,
  input  wire                              out_stall,
  output lobm_pkg::result_t                out_res,
  output logic                             out_last
);

  localparam int IW = $clog2(BOOK_DEPTH);
  localparam int PW = lobm_pkg::PRICE_W;
  localparam int QW = lobm_pkg::QTY_W;
  localparam int DW = lobm_pkg::ID_W;
  localparam int SW = lobm_pkg::SUM_W;

  logic          e_valid [BOOK_DEPTH];
  logic          e_buy   [BOOK_DEPTH];
  logic [PW-1:0] e_price [BOOK_DEPTH];
  logic [QW-1:0] e_qty   [BOOK_DEPTH];
  logic [DW-1:0] e_id    [BOOK_DEPTH];
  logic [SEQ_WIDTH-1:0] e_seq [BOOK_DEPTH];
  logic [SEQ_WIDTH-1:0] arrival;

  lobm_pkg::func_t c_func;
  logic          c_buy;
  logic          c_gfd;
  logic [PW-1:0] c_price;
  logic [DW-1:0] c_id;
  logic [QW-1:0] rem;

  logic [IW-1:0] idx;
  logic          id_found;
  logic [IW-1:0] id_slot;
  logic          free_found;
  logic [IW-1:0] free_slot;
  logic          best_found;
  logic [IW-1:0] best_slot;
  logic [PW-1:0] best_price;
  logic [SEQ_WIDTH-1:0] best_age;
  logic [DW-1:0] best_id;
  logic [QW-1:0] best_qty;

  logic          list_buy;
  logic          bounded;
  logic [PW-1:0] bound;
  logic          top_found;
  logic [PW-1:0] top;
  logic [SW-1:0] sum;

  logic              pend_valid;
  lobm_pkg::result_t pend;

  logic          scan_last;
  logic          first;
  logic          r_valid;
  logic          r_buy;
  logic [PW-1:0] r_price;
  logic [QW-1:0] r_qty;
  logic [DW-1:0] r_id;
  logic [SEQ_WIDTH-1:0] r_age;
  logic          cand;
  logic          better;
  logic          elig;
  logic [QW-1:0] fill_q;
  logic          out_free;
  logic          can_emit;
  logic          need_reject;
  logic          push_new;
  logic          load_out;
  lobm_pkg::result_t new_res;

  assign scan_last = (idx == IW'(BOOK_DEPTH - 1));
  assign first     = (idx == '0);
  assign r_valid   = e_valid[idx];
  assign r_buy     = e_buy[idx];
  assign r_price   = e_price[idx];
  assign r_qty     = e_qty[idx];
  assign r_id      = e_id[idx];
  assign r_age     = arrival - e_seq[idx];

  // A resting order crosses when it is on the other side and its price is
  // no worse than the incoming limit.
  assign cand = r_valid && (r_buy != c_buy) &&
                (c_buy ? (r_price <= c_price) : (r_price >= c_price));
  assign better = first || !best_found ||
                  (c_buy ? (r_price < best_price) : (r_price > best_price)) ||
                  ((r_price == best_price) && (r_age > best_age));
  assign elig = r_valid && (r_buy == list_buy) && (!bounded || (r_price < bound));

  assign fill_q   = (best_qty < rem) ? best_qty : rem;
  assign out_free = !out_valid || !out_stall;
  assign can_emit = !pend_valid || out_free;
  assign need_reject = (c_func == lobm_pkg::FUNC_NEW) && (rem != '0) && c_gfd &&
                       !free_found;
  assign load_out = pend_valid &&
                    (push_new || (cmd.op == lobm_pkg::OP_FLUSH));

  always_comb begin
    new_res  = '0;
    push_new = 1'b0;
    case (cmd.op)
      lobm_pkg::OP_FILL: begin
        push_new             = 1'b1;
        new_res.kind         = lobm_pkg::KIND_TRADE;
        new_res.first_id     = best_id;
        new_res.first_price  = best_price;
        new_res.second_id    = c_id;
        new_res.second_price = c_price;
        new_res.qty          = SW'(fill_q);
      end
      lobm_pkg::OP_REST: begin
        push_new            = need_reject;
        new_res.kind        = lobm_pkg::KIND_REJECT;
        new_res.first_id    = c_id;
        new_res.first_price = c_price;
        new_res.qty         = SW'(rem);
      end
      lobm_pkg::OP_HDR: begin
        push_new     = 1'b1;
        new_res.kind = lobm_pkg::KIND_SELL_HDR;
      end
      lobm_pkg::OP_LEVEL: begin
        if (top_found) begin
          push_new            = 1'b1;
          new_res.kind        = lobm_pkg::KIND_LEVEL;
          new_res.first_price = top;
          new_res.qty         = sum;
        end else if (!list_buy) begin
          push_new     = 1'b1;
          new_res.kind = lobm_pkg::KIND_BUY_HDR;
        end
      end
      default: push_new = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < BOOK_DEPTH; i++) e_valid[i] <= 1'b0;
      arrival    <= '0;
      idx        <= '0;
      out_valid  <= 1'b0;
      pend_valid <= 1'b0;
    end else begin
      // One result is held back so the final one of a command can be
      // marked last once the command is known to be complete.
      if (load_out) begin
        out_res   <= pend;
        out_last  <= (cmd.op == lobm_pkg::OP_FLUSH);
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      if (push_new) begin
        pend       <= new_res;
        pend_valid <= 1'b1;
      end

      if (cmd.op == lobm_pkg::OP_FIND || cmd.op == lobm_pkg::OP_CROSS ||
          cmd.op == lobm_pkg::OP_LIST) begin
        idx <= scan_last ? '0 : idx + 1'b1;
      end

      case (cmd.op)
        lobm_pkg::OP_LATCH: begin
          c_func  <= lobm_pkg::func_t'(func);
          c_buy   <= is_buy;
          c_gfd   <= is_gfd;
          c_price <= price;
          c_id    <= order_id;
          rem     <= quantity;
        end
        lobm_pkg::OP_FIND: begin
          if (first || !id_found) begin
            id_found <= r_valid && (r_id == c_id);
            id_slot  <= idx;
          end
        end
        lobm_pkg::OP_CANCEL: begin
          if (id_found) e_valid[id_slot] <= 1'b0;
        end
        lobm_pkg::OP_MODW: begin
          e_buy[id_slot]   <= c_buy;
          e_price[id_slot] <= c_price;
          e_seq[id_slot]   <= arrival;
        end
        lobm_pkg::OP_CROSS: begin
          if (cand && better) begin
            best_found <= 1'b1;
            best_slot  <= idx;
            best_price <= r_price;
            best_age   <= r_age;
            best_id    <= r_id;
            best_qty   <= r_qty;
          end else if (first) begin
            best_found <= 1'b0;
          end
          if (first || !free_found) begin
            free_found <= !r_valid;
            free_slot  <= idx;
          end
        end
        lobm_pkg::OP_FILL: begin
          e_qty[best_slot] <= best_qty - fill_q;
          if (best_qty == fill_q) e_valid[best_slot] <= 1'b0;
          rem <= rem - fill_q;
        end
        lobm_pkg::OP_REST: begin
          if (c_func == lobm_pkg::FUNC_MODIFY) begin
            e_qty[id_slot]   <= rem;
            e_valid[id_slot] <= (rem != '0);
          end else if ((rem != '0) && c_gfd && free_found) begin
            e_valid[free_slot] <= 1'b1;
            e_buy[free_slot]   <= c_buy;
            e_price[free_slot] <= c_price;
            e_qty[free_slot]   <= rem;
            e_id[free_slot]    <= c_id;
            e_seq[free_slot]   <= arrival;
          end
        end
        lobm_pkg::OP_HDR: begin
          list_buy <= 1'b0;
          bounded  <= 1'b0;
        end
        lobm_pkg::OP_LIST: begin
          if (elig && (first || !top_found || (r_price > top))) begin
            top_found <= 1'b1;
            top       <= r_price;
            sum       <= SW'(r_qty);
          end else if (elig && (r_price == top)) begin
            sum <= sum + SW'(r_qty);
          end else if (first) begin
            top_found <= 1'b0;
          end
        end
        lobm_pkg::OP_LEVEL: begin
          if (top_found) begin
            bound   <= top;
            bounded <= 1'b1;
          end else if (!list_buy) begin
            list_buy <= 1'b1;
            bounded  <= 1'b0;
          end
        end
        lobm_pkg::OP_FLUSH: begin
          if (pend_valid) pend_valid <= 1'b0;
          arrival <= arrival + 1'b1;
        end
        default: ;
      endcase
    end
  end

  assign status.func       = c_func;
  assign status.args_ok    = (c_price != '0) && (rem != '0);
  assign status.id_found   = id_found;
  assign status.scan_last  = scan_last;
  assign status.best_found = best_found;
  assign status.rem_zero   = (rem == '0);
  assign status.can_emit   = can_emit;
  assign status.flush_ok   = can_emit;
  assign status.top_found  = top_found;
  assign status.list_buy   = list_buy;

`ifndef SYNTHESIS
  a_fill_has_best: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == lobm_pkg::OP_FILL) |-> (best_found && (rem != '0)))
    else $error("fill issued without a crossing order");
  a_emit_has_room: assert property (@(posedge clk) disable iff (rst)
    push_new |-> can_emit)
    else $error("result produced with no room to hold it");
  a_flush_empties: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == lobm_pkg::OP_FLUSH) |=> !pend_valid)
    else $error("held result survived the end of a command");
  a_scan_wraps: assert property (@(posedge clk) disable iff (rst)
    ((cmd.op == lobm_pkg::OP_FIND) && scan_last) |=> (idx == '0))
    else $error("scan index did not return to the first slot");
`endif

endmodule

`default_nettype wire

[hw/rtl/limit_order_book_matcher_core.sv]
// ----------------------------------------------------------------------------
// limit_order_book_matcher_core: price-time priority order book matcher
// Matches numeric-id limit orders against a bounded book and lists levels.
// ----------------------------------------------------------------------------
// Every command first looks up its id in a scan over all BOOK_DEPTH slots.
// New and modify run matching passes; each scans the book for the best
// crossing order and fills it, until the order is filled or none crosses.
// Print lists each side by repeated scans, each finding the next lower level.
// One command is in work at a time; results leave through an output register.
// Reset clears the valid bits and arrival counter.
`default_nettype none

module limit_order_book_matcher_core #(
  parameter int BOOK_DEPTH = 32,
  parameter int SEQ_WIDTH  = 32
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         in_valid,
  output logic        in_stall,
  input  wire  [1:0]  func,
  input  wire         is_buy,
  input  wire         is_gfd,
  input  wire  [30:0] price,
  input  wire  [30:0] quantity,
  input  wire  [31:0] order_id,
  output logic        out_valid,
  input  wire         out_stall,
  output logic [2:0]  kind,
  output logic [31:0] first_id,
  output logic [30:0] first_price,
  output logic [31:0] second_id,
  output logic [30:0] second_price,
  output logic [35:0] fill_or_level_qty,
  output logic        last
);

  lobm_pkg::cmd_t    cmd;
  lobm_pkg::status_t status;
  lobm_pkg::result_t res;

  lobm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  lobm_dp #(
    .BOOK_DEPTH (BOOK_DEPTH),
    .SEQ_WIDTH  (SEQ_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .func      (func),
    .is_buy    (is_buy),
    .is_gfd    (is_gfd),
    .price     (price),
    .quantity  (quantity),
    .order_id  (order_id),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (res),
    .out_last  (last)
  );

  assign kind              = res.kind;
  assign first_id          = res.first_id;
  assign first_price       = res.first_price;
  assign second_id         = res.second_id;
  assign second_price      = res.second_price;
  assign fill_or_level_qty = res.qty;

endmodule

`default_nettype wire

[verif/tb_limit_order_book_matcher_core.sv]
// ----------------------------------------------------------------------------
// tb_limit_order_book_matcher_core: testbench of the order book matcher
// Sends order commands with random gaps, predicts trades, rejects and book
// listings with a behavioral copy of the book, and checks every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_limit_order_book_matcher_core;

  localparam int DEPTH = 32;
  localparam int CYCLE_LIMIT = 3000000;

  typedef struct packed {
    lobm_pkg::kind_t                  kind;
    logic [lobm_pkg::ID_W-1:0]        first_id;
    logic [lobm_pkg::PRICE_W-1:0]     first_price;
    logic [lobm_pkg::ID_W-1:0]        second_id;
    logic [lobm_pkg::PRICE_W-1:0]     second_price;
    logic [lobm_pkg::SUM_W-1:0]       qty;
    logic                             last;
  } book_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] func = lobm_pkg::FUNC_NEW;
  logic is_buy = 1'b0;
  logic is_gfd = 1'b0;
  logic [30:0] price = '0;
  logic [30:0] quantity = '0;
  logic [31:0] order_id = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [2:0] kind;
  logic [31:0] first_id;
  logic [30:0] first_price;
  logic [31:0] second_id;
  logic [30:0] second_price;
  logic [35:0] fill_or_level_qty;
  logic last;

  // Behavioral copy of the book.
  logic        bk_valid [DEPTH];
  logic        bk_buy   [DEPTH];
  logic [30:0] bk_price [DEPTH];
  logic [30:0] bk_qty   [DEPTH];
  logic [31:0] bk_id    [DEPTH];
  logic [31:0] bk_seq   [DEPTH];
  logic [31:0] arrivals;

  book_result_t expected_results[$];
  int mismatches = 0;
  int cycles = 0;
  bit idle_free = 1'b0;
  bit hold_receiver = 1'b0;
  int hold_cycles = 0;

  limit_order_book_matcher_core u_top (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .func(func), .is_buy(is_buy), .is_gfd(is_gfd), .price(price),
    .quantity(quantity), .order_id(order_id), .out_valid(out_valid),
    .out_stall(out_stall), .kind(kind), .first_id(first_id),
    .first_price(first_price), .second_id(second_id),
    .second_price(second_price), .fill_or_level_qty(fill_or_level_qty),
    .last(last)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_limit_order_book_matcher_core NOT OK");
      $finish;
    end
  end

  // Receiver stall, with a long hold-off on request.
  always @(posedge clk) begin
    if (hold_receiver) begin
      out_stall <= 1'b1;
      hold_cycles <= hold_cycles + 1;
    end else begin
      out_stall <= !idle_free && ($urandom_range(99) < 19);
      hold_cycles <= 0;
    end
  end

  always @(posedge clk) begin
    book_result_t got, want;
    if (!rst && out_valid && !out_stall) begin
      got = '{lobm_pkg::kind_t'(kind), first_id, first_price, second_id, second_price,
              fill_or_level_qty, last};
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", got);
      end else begin
        want = expected_results.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p, got %p", want, got);
        end
      end
    end
  end

  function automatic void push_result(lobm_pkg::kind_t k, logic [31:0] fid,
                                      logic [30:0] fp, logic [31:0] sid,
                                      logic [30:0] sp, logic [35:0] q);
    expected_results.push_back('{k, fid, fp, sid, sp, q, 1'b0});
  endfunction

  function automatic int find_order(logic [31:0] id);
    for (int i = 0; i < DEPTH; i++)
      if (bk_valid[i] && bk_id[i] == id) return i;
    return -1;
  endfunction

  // Fills the incoming order against the best opposite orders.
  function automatic logic [30:0] match_order(logic buy, logic [30:0] lim,
                                              logic [31:0] id, logic [30:0] rem);
    int best;
    logic [30:0] q;
    while (rem != 0) begin
      best = -1;
      for (int i = 0; i < DEPTH; i++) begin
        if (!bk_valid[i] || bk_buy[i] == buy) continue;
        if (buy ? (bk_price[i] > lim) : (bk_price[i] < lim)) continue;
        if (best < 0 ||
            (buy ? (bk_price[i] < bk_price[best]) : (bk_price[i] > bk_price[best])) ||
            (bk_price[i] == bk_price[best] &&
             (arrivals - bk_seq[i]) > (arrivals - bk_seq[best])))
          best = i;
      end
      if (best < 0) break;
      q = (bk_qty[best] < rem) ? bk_qty[best] : rem;
      bk_qty[best] -= q;
      rem -= q;
      push_result(lobm_pkg::KIND_TRADE, bk_id[best], bk_price[best], id, lim, 36'(q));
      if (bk_qty[best] == 0) bk_valid[best] = 1'b0;
    end
    return rem;
  endfunction

  function automatic void list_levels(logic buy);
    logic bounded;
    logic found;
    logic [30:0] bound, top;
    logic [35:0] sum;
    bounded = 1'b0;
    bound = '0;
    forever begin
      found = 1'b0;
      top = '0;
      sum = '0;
      for (int i = 0; i < DEPTH; i++) begin
        if (!bk_valid[i] || bk_buy[i] != buy) continue;
        if (bounded && bk_price[i] >= bound) continue;
        if (!found || bk_price[i] > top) begin
          top = bk_price[i];
          found = 1'b1;
        end
      end
      if (!found) break;
      for (int i = 0; i < DEPTH; i++)
        if (bk_valid[i] && bk_buy[i] == buy && bk_price[i] == top) sum += bk_qty[i];
      push_result(lobm_pkg::KIND_LEVEL, '0, top, '0, '0, sum);
      bound = top;
      bounded = 1'b1;
    end
  endfunction

  function automatic void predict_command(lobm_pkg::func_t f, logic buy, logic gfd,
                                          logic [30:0] p, logic [30:0] q,
                                          logic [31:0] id);
    int n_before, slot;
    logic [30:0] rem;
    n_before = expected_results.size();
    case (f)
      lobm_pkg::FUNC_NEW: begin
        if (p != 0 && q != 0 && find_order(id) < 0) begin
          rem = match_order(buy, p, id, q);
          if (rem != 0 && gfd) begin
            slot = -1;
            for (int i = DEPTH - 1; i >= 0; i--) if (!bk_valid[i]) slot = i;
            if (slot < 0) begin
              push_result(lobm_pkg::KIND_REJECT, id, p, '0, '0, 36'(rem));
            end else begin
              bk_valid[slot] = 1'b1;
              bk_buy[slot] = buy;
              bk_price[slot] = p;
              bk_qty[slot] = rem;
              bk_id[slot] = id;
              bk_seq[slot] = arrivals;
            end
          end
        end
      end
      lobm_pkg::FUNC_MODIFY: begin
        slot = find_order(id);
        if (p != 0 && q != 0 && slot >= 0) begin
          bk_buy[slot] = buy;
          bk_price[slot] = p;
          bk_seq[slot] = arrivals;
          rem = match_order(buy, p, id, q);
          bk_qty[slot] = rem;
          if (rem == 0) bk_valid[slot] = 1'b0;
        end
      end
      lobm_pkg::FUNC_CANCEL: begin
        slot = find_order(id);
        if (slot >= 0) bk_valid[slot] = 1'b0;
      end
      default: begin
        push_result(lobm_pkg::KIND_SELL_HDR, '0, '0, '0, '0, '0);
        list_levels(1'b0);
        push_result(lobm_pkg::KIND_BUY_HDR, '0, '0, '0, '0, '0);
        list_levels(1'b1);
      end
    endcase
    arrivals = arrivals + 1;
    if (expected_results.size() > n_before)
      expected_results[expected_results.size() - 1].last = 1'b1;
  endfunction

  // The item stays offered after its transfer; the caller or the next idle
  // cycle takes valid down.
  task automatic send_command(lobm_pkg::func_t f, logic buy, logic gfd, logic [30:0] p,
                              logic [30:0] q, logic [31:0] id);
    if (!idle_free)
      while ($urandom_range(99) < 19) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    predict_command(f, buy, gfd, p, q, id);
    in_valid <= 1'b1;
    func <= f;
    is_buy <= buy;
    is_gfd <= gfd;
    price <= p;
    quantity <= q;
    order_id <= id;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  // Random command; orders use a narrow price band so that they cross.
  task automatic send_random_order(int id_span);
    int r;
    r = $urandom_range(99);
    if (r < 55)
      send_command(lobm_pkg::FUNC_NEW, 1'($urandom_range(1)), $urandom_range(99) < 75,
                   31'(95 + $urandom_range(10)), 31'(1 + $urandom_range(20)),
                   32'($urandom_range(id_span)));
    else if (r < 70)
      send_command(lobm_pkg::FUNC_MODIFY, 1'($urandom_range(1)), 1'($urandom_range(1)),
                   31'(95 + $urandom_range(10)), 31'(1 + $urandom_range(20)),
                   32'($urandom_range(id_span)));
    else if (r < 82)
      send_command(lobm_pkg::FUNC_CANCEL, 1'($urandom_range(1)), 1'($urandom_range(1)),
                   31'($urandom), 31'($urandom), 32'($urandom_range(id_span)));
    else if (r < 90)
      send_command(lobm_pkg::FUNC_PRINT, 1'($urandom_range(1)), 1'($urandom_range(1)),
                   31'($urandom), 31'($urandom), $urandom);
    else
      // Noise: zero fields, wide values.
      send_command(lobm_pkg::func_t'($urandom_range(1)), 1'($urandom_range(1)),
                   1'($urandom_range(1)),
                   ($urandom_range(1) ? 31'($urandom) : 31'd0),
                   ($urandom_range(1) ? 31'($urandom) : 31'd0), $urandom);
  endtask

  task automatic test_directed();
    send_command(lobm_pkg::FUNC_PRINT, 1'b0, 1'b0, '0, '0, '0);
    send_command(lobm_pkg::FUNC_NEW, 1'b1, 1'b1, 31'h7FFFFFFF, 31'h7FFFFFFF, 32'hFFFFFFFF);
    send_command(lobm_pkg::FUNC_NEW, 1'b1, 1'b1, 31'd5, 31'd3, 32'hFFFFFFFF);  // duplicate id
    send_command(lobm_pkg::FUNC_NEW, 1'b0, 1'b1, 31'd0, 31'd3, 32'd1);          // zero price
    send_command(lobm_pkg::FUNC_NEW, 1'b0, 1'b1, 31'd3, 31'd0, 32'd1);          // zero quantity
    send_command(lobm_pkg::FUNC_NEW, 1'b0, 1'b0, 31'd1, 31'd10, 32'd0);         // IOC crosses
    send_command(lobm_pkg::FUNC_NEW, 1'b1, 1'b1, 31'd100, 31'd10, 32'd2);
    send_command(lobm_pkg::FUNC_NEW, 1'b1, 1'b1, 31'd100, 31'd7, 32'd3);
    send_command(lobm_pkg::FUNC_NEW, 1'b0, 1'b1, 31'd200, 31'd4, 32'd4);
    send_command(lobm_pkg::FUNC_PRINT, 1'b1, 1'b1, '1, '1, '1);
    send_command(lobm_pkg::FUNC_NEW, 1'b0, 1'b1, 31'd90, 31'd15, 32'd5);        // best price first
    send_command(lobm_pkg::FUNC_MODIFY, 1'b1, 1'b1, 31'd250, 31'd6, 32'd3);     // modify reprices
    send_command(lobm_pkg::FUNC_MODIFY, 1'b1, 1'b1, 31'd0, 31'd6, 32'd2);       // ignored
    send_command(lobm_pkg::FUNC_MODIFY, 1'b1, 1'b1, 31'd9, 31'd6, 32'd77);      // unknown id
    send_command(lobm_pkg::FUNC_CANCEL, 1'b0, 1'b0, '0, '0, 32'd77);            // unknown id
    send_command(lobm_pkg::FUNC_CANCEL, 1'b0, 1'b0, '0, '0, 32'hFFFFFFFF);
    send_command(lobm_pkg::FUNC_PRINT, 1'b0, 1'b0, '0, '0, '0);
    drain_results();
  endtask

  // Fill the book with non-crossing sells, then overflow it.
  task automatic test_full_book();
    for (int i = 0; i < DEPTH + 3; i++)
      send_command(lobm_pkg::FUNC_NEW, 1'b0, 1'b1, 31'(1000 + i), 31'(i + 1),
                   32'(500 + i));
    send_command(lobm_pkg::FUNC_NEW, 1'b1, 1'b1, 31'd1000, 31'd5, 32'd900);  // fill, rest
    send_command(lobm_pkg::FUNC_PRINT, 1'b0, 1'b0, '0, '0, '0);
    send_command(lobm_pkg::FUNC_NEW, 1'b1, 1'b0, 31'h7FFFFFFF, 31'h7FFFFFFF,
                 32'd901);  // sweep
    send_command(lobm_pkg::FUNC_PRINT, 1'b0, 1'b0, '0, '0, '0);
    drain_results();
  endtask

  // Listings give several results each, so the held receiver fills the
  // output side and the block stalls its input.
  task automatic test_receiver_hold();
    hold_receiver = 1'b1;
    fork
      begin
        send_command(lobm_pkg::FUNC_PRINT, 1'b0, 1'b0, '0, '0, '0);
        send_command(lobm_pkg::FUNC_PRINT, 1'b0, 1'b0, '0, '0, '0);
        for (int i = 0; i < 10; i++) send_random_order(40);
        in_valid <= 1'b0;
      end
      begin
        @(posedge clk);
        while (hold_cycles < 3000) @(posedge clk);
        hold_receiver = 1'b0;
      end
    join
    drain_results();
  endtask

  task automatic test_random();
    for (int i = 0; i < 40; i++) send_random_order(40);
    idle_free = 1'b1;
    for (int i = 0; i < 25; i++) send_random_order(40);
    idle_free = 1'b0;
    for (int i = 0; i < 40; i++) send_random_order(40);
    drain_results();
  endtask

  initial begin
    for (int i = 0; i < DEPTH; i++) bk_valid[i] = 1'b0;
    arrivals = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_full_book();
    test_receiver_hold();
    test_random();
    if (mismatches == 0 && expected_results.size() == 0)
      $display("tb_limit_order_book_matcher_core OK");
    else
      $display("tb_limit_order_book_matcher_core NOT OK");
    $finish;
  end

endmodule
